@@ src/assert_macros.svh @@
// assertion macros shared by the indexed list stack modules
// no dependencies; expects clk and rst_n in the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define ILST_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked on every clock edge outside reset
`define ILST_ASSERT_IMP(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

@@ src/ilst_pkg.sv @@
// shared types and constants of the indexed list stack
// no dependencies
`default_nettype none

package ilst_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;

    localparam int OPCODE_W   = 3;
    localparam int POSITION_W = 5;
    localparam int VALUE_W    = 32;
    localparam int COUNT_W    = 5;
    localparam int STATUS_W   = 2;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = ((CNT_W > POSITION_W) ? CNT_W : POSITION_W) + 1;

    localparam logic [OPCODE_W-1:0] OP_PUSH   = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_POP    = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_INSERT = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_REMOVE = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_SET    = 3'd4;
    localparam logic [OPCODE_W-1:0] OP_READ   = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

    typedef struct packed {
        logic load_in;
        logic exec;
    } ctrl_t;

endpackage

`default_nettype wire

@@ src/ilst_ctrl.sv @@
// controller of the indexed list stack: handshakes and sequencing
// depends on ilst_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module ilst_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_stall,
    output logic           res_valid,
    input  logic           res_stall,
    output ilst_pkg::ctrl_t ctrl
);
    import ilst_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   res_valid_reg;
    logic   res_valid_next;
    logic   out_free;

    assign out_free     = !res_valid_reg || !res_stall;
    assign cmd_stall    = (state_reg != S_IDLE);
    assign ctrl.load_in = (state_reg == S_IDLE) && cmd_valid;
    assign ctrl.exec    = (state_reg == S_EXEC) && out_free;
    assign res_valid    = res_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (ctrl.exec)
        begin
            res_valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    `ILST_ASSERT_IMP(a_accept_to_exec, ctrl.load_in, state_reg == S_EXEC,
        "accepted transfer did not start execution")
    `ILST_ASSERT_IMP(a_exec_gives_result, ctrl.exec, res_valid_reg && state_reg == S_IDLE,
        "execution did not produce a result")

endmodule

`default_nettype wire

@@ src/ilst_dp.sv @@
// datapath of the indexed list stack: entry registers, count and result register
// depends on ilst_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module ilst_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  ilst_pkg::ctrl_t                   ctrl,
    input  logic [ilst_pkg::OPCODE_W-1:0]     opcode,
    input  logic [ilst_pkg::POSITION_W-1:0]   position,
    input  logic [ilst_pkg::VALUE_W-1:0]      value,
    output logic [ilst_pkg::VALUE_W-1:0]      result_value,
    output logic [ilst_pkg::COUNT_W-1:0]      element_count,
    output logic [ilst_pkg::STATUS_W-1:0]     status
);
    import ilst_pkg::*;

    logic [OPCODE_W-1:0]   op_reg;
    logic [POSITION_W-1:0] pos_reg;
    logic [DATA_WIDTH-1:0] val_reg;
    logic [DATA_WIDTH-1:0] entries_reg [DEPTH];
    logic [DATA_WIDTH-1:0] entries_next [DEPTH];
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic [VALUE_W-1:0]    res_value_reg;
    logic [COUNT_W-1:0]    res_count_reg;
    logic [STATUS_W-1:0]   res_status_reg;

    logic [DATA_WIDTH+VALUE_W-1:0] val_ext;
    logic [DATA_WIDTH+VALUE_W-1:0] rd_ext;
    logic [CNT_W+COUNT_W-1:0]      cnt_out_ext;
    logic [CMP_W-1:0]              cnt_cmp;
    logic [CMP_W-1:0]              pos_cmp;
    logic [CMP_W-1:0]              idx_full;
    logic [IDX_W-1:0]              op_idx;
    logic [DATA_WIDTH-1:0]         rd_data;
    logic                          full;
    logic                          empty;
    logic                          do_ins;
    logic                          do_rem;
    logic                          do_set;
    logic                          take;
    logic [STATUS_W-1:0]           st;

    assign val_ext = {{DATA_WIDTH{1'b0}}, value};
    assign cnt_cmp = CMP_W'(count_reg);
    assign pos_cmp = CMP_W'(pos_reg);
    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign op_idx  = idx_full[IDX_W-1:0];
    assign rd_data = entries_reg[op_idx];
    assign rd_ext  = {{VALUE_W{1'b0}}, rd_data};

    // operation decode and checks
    always_comb
    begin
        do_ins   = 1'b0;
        do_rem   = 1'b0;
        do_set   = 1'b0;
        take     = 1'b0;
        st       = ST_OK;
        idx_full = pos_cmp - CMP_W'(1);
        case (op_reg)
            OP_PUSH:
            begin
                if (full)
                begin
                    st = ST_FULL;
                end
                else
                begin
                    do_ins   = 1'b1;
                    idx_full = cnt_cmp;
                end
            end
            OP_POP:
            begin
                if (empty)
                begin
                    st = ST_EMPTY;
                end
                else
                begin
                    do_rem   = 1'b1;
                    take     = 1'b1;
                    idx_full = cnt_cmp - CMP_W'(1);
                end
            end
            OP_INSERT:
            begin
                if (full)
                begin
                    st = ST_FULL;
                end
                else if (pos_cmp == '0 || pos_cmp > cnt_cmp + CMP_W'(1))
                begin
                    st = ST_RANGE;
                end
                else
                begin
                    do_ins = 1'b1;
                end
            end
            OP_REMOVE, OP_SET, OP_READ:
            begin
                if (empty)
                begin
                    st = ST_EMPTY;
                end
                else if (pos_cmp == '0 || pos_cmp > cnt_cmp)
                begin
                    st = ST_RANGE;
                end
                else if (op_reg == OP_REMOVE)
                begin
                    do_rem = 1'b1;
                    take   = 1'b1;
                end
                else if (op_reg == OP_SET)
                begin
                    do_set = 1'b1;
                end
                else
                begin
                    take = 1'b1;
                end
            end
            default:
            begin
                st = ST_OK;
            end
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (do_ins)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_rem)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    assign cnt_out_ext = {{COUNT_W{1'b0}}, count_next};

    // each entry takes the new value, its lower or upper neighbor, or holds, in parallel
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_entry
        always_comb
        begin
            entries_next[g] = entries_reg[g];
            if (do_ins && IDX_W'(g) == op_idx)
            begin
                entries_next[g] = val_reg;
            end
            else if (do_set && IDX_W'(g) == op_idx)
            begin
                entries_next[g] = val_reg;
            end
            else if (do_ins && IDX_W'(g) > op_idx)
            begin
                if (g > 0)
                begin
                    entries_next[g] = entries_reg[(g > 0) ? g - 1 : 0];
                end
            end
            else if (do_rem && IDX_W'(g) >= op_idx)
            begin
                if (g < DEPTH - 1)
                begin
                    entries_next[g] = entries_reg[(g < DEPTH - 1) ? g + 1 : g];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (ctrl.exec)
            begin
                entries_reg[g] <= entries_next[g];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_in)
        begin
            op_reg  <= opcode;
            pos_reg <= position;
            val_reg <= val_ext[DATA_WIDTH-1:0];
        end
        if (ctrl.exec)
        begin
            res_value_reg  <= take ? rd_ext[VALUE_W-1:0] : '0;
            res_count_reg  <= cnt_out_ext[COUNT_W-1:0];
            res_status_reg <= st;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (ctrl.exec)
        begin
            count_reg <= count_next;
        end
    end

    assign result_value  = res_value_reg;
    assign element_count = res_count_reg;
    assign status        = res_status_reg;

    `ILST_ASSERT(a_count_bound, count_reg <= CNT_W'(DEPTH),
        "element count above depth")
    `ILST_ASSERT_IMP(a_insert_grows, ctrl.exec && do_ins,
        count_reg == $past(count_reg) + CNT_W'(1), "insert did not grow the list")

endmodule

`default_nettype wire

@@ src/indexed_list_stack_top.sv @@
// indexed list stack: bounded ordered list of signed values with stack access
// channels: command (cmd_valid/cmd_stall with opcode, position, value) and
// result (res_valid/res_stall with result_value, element_count, status)
// operations: push, pop, insert, remove, set and read at a one-based position;
// every command transfer yields exactly one result transfer
// a taken command moves to the execute state; once the result register is
// free it is executed, the result register is loaded and res_valid rises
// a new command is taken only after the last one has executed; a command is
// captured, then executed, where on insert or remove the entries from its
// position up shift one place in parallel and the result register is loaded
// the result register parts the two channels: a new command is taken while
// a finished result still waits to be taken
// while res_stall is high the result holds; a pending command waits in the
// execute step until the result register frees up, and cmd_stall stays high
// reset: the list is empty, no result is pending, a command is taken at once
// depends on ilst_pkg, ilst_ctrl and ilst_dp
`default_nettype none

module indexed_list_stack_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cmd_valid,
    output logic                            cmd_stall,
    input  logic [ilst_pkg::OPCODE_W-1:0]   opcode,
    input  logic [ilst_pkg::POSITION_W-1:0] position,
    input  logic [ilst_pkg::VALUE_W-1:0]    value,
    output logic                            res_valid,
    input  logic                            res_stall,
    output logic [ilst_pkg::VALUE_W-1:0]    result_value,
    output logic [ilst_pkg::COUNT_W-1:0]    element_count,
    output logic [ilst_pkg::STATUS_W-1:0]   status
);
    import ilst_pkg::*;

    ctrl_t ctrl;

    ilst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .ctrl      (ctrl)
    );

    ilst_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .opcode        (opcode),
        .position      (position),
        .value         (value),
        .result_value  (result_value),
        .element_count (element_count),
        .status        (status)
    );

endmodule

`default_nettype wire

@@ test/indexed_list_stack_top_tb.sv @@
// self-checking testbench for indexed_list_stack_top: directed and random commands
// with random command gaps and result stalls, checked against a scoreboard that models the list
// depends on ilst_pkg and indexed_list_stack_top
`default_nettype none

module indexed_list_stack_top_tb;

    import ilst_pkg::*;

    localparam logic [OPCODE_W-1:0] OP_SPARE_LO = 3'd6;
    localparam logic [OPCODE_W-1:0] OP_SPARE_HI = 3'd7;

    localparam int RANDOM_ITEMS   = 380;
    localparam int HOLD_CYCLES    = 40;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES  = 8;

    typedef struct packed {
        logic [VALUE_W-1:0]  result_value;
        logic [COUNT_W-1:0]  element_count;
        logic [STATUS_W-1:0] status;
    } outcome_t;

    class list_scoreboard;
        logic [DATA_WIDTH-1:0] slots [DEPTH];
        int                    stored;
        outcome_t              expected_outcomes [$];
        int                    failures;

        function new();
            stored   = 0;
            failures = 0;
        endfunction

        function outcome_t apply_command(logic [OPCODE_W-1:0] op, logic [POSITION_W-1:0] pos,
                                         logic [VALUE_W-1:0] val);
            outcome_t              o;
            logic [DATA_WIDTH-1:0] taken;
            int                    p;
            int                    i;
            o     = '0;
            taken = '0;
            p     = int'(pos);
            case (op)
                OP_PUSH:
                    if (stored >= DEPTH)
                        o.status = ST_FULL;
                    else
                    begin
                        slots[stored] = val[DATA_WIDTH-1:0];
                        stored++;
                    end
                OP_POP:
                    if (stored == 0)
                        o.status = ST_EMPTY;
                    else
                    begin
                        stored--;
                        taken = slots[stored];
                    end
                OP_INSERT:
                    if (stored >= DEPTH)
                        o.status = ST_FULL;
                    else if (p < 1 || p > stored + 1)
                        o.status = ST_RANGE;
                    else
                    begin
                        for (i = stored; i > p - 1; i--)
                            slots[i] = slots[i-1];
                        slots[p-1] = val[DATA_WIDTH-1:0];
                        stored++;
                    end
                OP_REMOVE, OP_SET, OP_READ:
                    if (stored == 0)
                        o.status = ST_EMPTY;
                    else if (p < 1 || p > stored)
                        o.status = ST_RANGE;
                    else if (op == OP_REMOVE)
                    begin
                        taken = slots[p-1];
                        for (i = p - 1; i + 1 < stored; i++)
                            slots[i] = slots[i+1];
                        stored--;
                    end
                    else if (op == OP_SET)
                        slots[p-1] = val[DATA_WIDTH-1:0];
                    else
                        taken = slots[p-1];
                default:
                    ;
            endcase
            o.result_value  = VALUE_W'(taken);
            o.element_count = COUNT_W'(stored);
            return o;
        endfunction

        function void note_command(logic [OPCODE_W-1:0] op, logic [POSITION_W-1:0] pos,
                                   logic [VALUE_W-1:0] val);
            expected_outcomes.push_back(apply_command(op, pos, val));
        endfunction

        function void report(string field, logic [VALUE_W-1:0] want, logic [VALUE_W-1:0] got);
            failures++;
            $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
        endfunction

        function void check_result(logic [VALUE_W-1:0] rv, logic [COUNT_W-1:0] cnt,
                                   logic [STATUS_W-1:0] st);
            outcome_t want;
            if (expected_outcomes.size() == 0)
            begin
                failures++;
                $display("%0t: unexpected result, expected none actual %h %0d %0d",
                         $time, rv, cnt, st);
                return;
            end
            want = expected_outcomes.pop_front();
            if (rv !== want.result_value)
                report("result_value", want.result_value, rv);
            if (cnt !== want.element_count)
                report("element_count", VALUE_W'(want.element_count), VALUE_W'(cnt));
            if (st !== want.status)
                report("status", VALUE_W'(want.status), VALUE_W'(st));
        endfunction

        function int pending();
            return expected_outcomes.size();
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  cmd_valid = 1'b0;
    logic                  cmd_stall;
    logic [OPCODE_W-1:0]   opcode    = '0;
    logic [POSITION_W-1:0] position  = '0;
    logic [VALUE_W-1:0]    value     = '0;
    logic                  res_valid;
    logic                  res_stall = 1'b0;
    logic [VALUE_W-1:0]    result_value;
    logic [COUNT_W-1:0]    element_count;
    logic [STATUS_W-1:0]   status;

    list_scoreboard sb = new();
    bit             quiet_tail   = 1'b0;
    bit             hold_results = 1'b0;
    int             list_len     = 0;
    int             idle_cycles  = 0;

    indexed_list_stack_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (cmd_valid),
        .cmd_stall     (cmd_stall),
        .opcode        (opcode),
        .position      (position),
        .value         (value),
        .res_valid     (res_valid),
        .res_stall     (res_stall),
        .result_value  (result_value),
        .element_count (element_count),
        .status        (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // transfer monitor: results are checked before the same-edge command is noted
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_valid && !res_stall)
                sb.check_result(result_value, element_count, status);
            if (cmd_valid && !cmd_stall)
                sb.note_command(opcode, position, value);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (cmd_valid && !cmd_stall) || (res_valid && !res_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin : result_side
        @(posedge rst_n);
        forever
        begin
            if (hold_results)
            begin
                res_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_results = 1'b0;
            end
            else if (quiet_tail || $urandom_range(0, 3) != 0)
            begin
                res_stall <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
            else
            begin
                res_stall <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
    end

    task automatic issue(input logic [OPCODE_W-1:0] op, input logic [POSITION_W-1:0] pos,
                         input logic [VALUE_W-1:0] val, input bit allow_gap);
        int p;
        p = int'(pos);
        opcode    <= op;
        position  <= pos;
        value     <= val;
        cmd_valid <= 1'b1;
        do
            @(posedge clk);
        while (cmd_stall);
        case (op)
            OP_PUSH:   if (list_len < DEPTH) list_len++;
            OP_POP:    if (list_len > 0) list_len--;
            OP_INSERT: if (list_len < DEPTH && p >= 1 && p <= list_len + 1) list_len++;
            OP_REMOVE: if (list_len > 0 && p >= 1 && p <= list_len) list_len--;
            default:   ;
        endcase
        if (allow_gap && !quiet_tail && $urandom_range(0, 3) == 0)
        begin
            cmd_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    // bias 0 grows the list, 1 keeps it level, 2 shrinks it
    task automatic random_command(input int bias, output logic [OPCODE_W-1:0] op,
                                  output logic [POSITION_W-1:0] pos,
                                  output logic [VALUE_W-1:0] val);
        int roll;
        int grow;
        int shrink;
        int top;
        grow   = (bias == 0) ? 60 : (bias == 1) ? 30 : 15;
        shrink = (bias == 2) ? 60 : (bias == 1) ? 30 : 15;
        roll   = $urandom_range(0, 99);
        if (roll < 3)
            op = (roll == 0) ? OP_SPARE_LO : OP_SPARE_HI;
        else if (roll < 3 + grow)
            op = $urandom_range(0, 1) ? OP_PUSH : OP_INSERT;
        else if (roll < 3 + grow + shrink)
            op = $urandom_range(0, 1) ? OP_POP : OP_REMOVE;
        else
            op = $urandom_range(0, 1) ? OP_SET : OP_READ;

        case ($urandom_range(0, 9))
            0:       val = 32'h8000_0000;
            1:       val = 32'h7fff_ffff;
            2:       val = $urandom_range(0, 1) ? 32'hffff_ffff : 32'h0000_0000;
            default: val = $urandom;
        endcase

        top = (op == OP_INSERT) ? list_len + 1 : list_len;
        if (op == OP_PUSH || op == OP_POP || op == OP_SPARE_LO || op == OP_SPARE_HI)
            pos = POSITION_W'($urandom_range(0, 31));
        else if ($urandom_range(0, 99) < 85 && top >= 1)
            pos = POSITION_W'($urandom_range(1, top));
        else
        begin
            case ($urandom_range(0, 3))
                0:       pos = '0;
                1:       pos = POSITION_W'(top + 1);
                2:       pos = POSITION_W'(top + 2);
                default: pos = POSITION_W'($urandom_range(0, 31));
            endcase
        end
    endtask

    initial
    begin : command_side
        logic [OPCODE_W-1:0]   op;
        logic [POSITION_W-1:0] pos;
        logic [VALUE_W-1:0]    val;
        int                    k;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list, range errors, insert acting as push, top position repairs
        issue(OP_POP,      5'd0,  32'h0,         1'b1);
        issue(OP_READ,     5'd1,  32'h0,         1'b1);
        issue(OP_REMOVE,   5'd1,  32'h0,         1'b1);
        issue(OP_SET,      5'd1,  32'hffff_ffff, 1'b1);
        issue(OP_INSERT,   5'd0,  32'h1111_1111, 1'b1);
        issue(OP_INSERT,   5'd2,  32'h2222_2222, 1'b1);
        issue(OP_INSERT,   5'd1,  32'h7fff_ffff, 1'b1);
        issue(OP_PUSH,     5'd31, 32'h8000_0000, 1'b1);
        issue(OP_PUSH,     5'd0,  32'hffff_ffff, 1'b1);
        issue(OP_PUSH,     5'd16, 32'h0000_0000, 1'b1);
        issue(OP_INSERT,   5'd2,  32'h1234_5678, 1'b1);
        issue(OP_INSERT,   5'd6,  32'ha5a5_a5a5, 1'b1);
        issue(OP_READ,     5'd0,  32'h0,         1'b1);
        issue(OP_READ,     5'd7,  32'h0,         1'b1);
        issue(OP_READ,     5'd31, 32'h0,         1'b1);
        issue(OP_READ,     5'd6,  32'h0,         1'b1);
        issue(OP_SET,      5'd6,  32'h5a5a_5a5a, 1'b1);
        issue(OP_SET,      5'd1,  32'h0000_0000, 1'b1);
        issue(OP_REMOVE,   5'd6,  32'h0,         1'b1);
        issue(OP_REMOVE,   5'd2,  32'h0,         1'b1);
        issue(OP_REMOVE,   5'd0,  32'h0,         1'b1);
        issue(OP_REMOVE,   5'd5,  32'h0,         1'b1);
        issue(OP_SPARE_LO, 5'd31, 32'hffff_ffff, 1'b1);
        issue(OP_SPARE_HI, 5'd17, 32'h8000_0001, 1'b1);
        issue(OP_POP,      5'd0,  32'h0,         1'b1);

        for (k = 0; k < RANDOM_ITEMS; k++)
        begin
            if (k == 150)
                hold_results = 1'b1;
            if (k == 260)
            begin
                cmd_valid <= 1'b0;
                // let the monitor note the last transfer before waiting
                @(posedge clk);
                while (sb.pending() != 0)
                    @(posedge clk);
            end
            if (k == RANDOM_ITEMS - 60)
                quiet_tail = 1'b1;
            random_command((k / 40) % 3, op, pos, val);
            issue(op, pos, val, !(k >= 150 && k < 170));
        end

        cmd_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
